>>> rtl/assert_macros.svh
// assertion helpers, compiled out with ASSERT_OFF
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/sha_pkg.sv
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // one message word between front and back
    typedef struct packed {
        logic [31:0] data;
        logic        last;
    } t_word;

    localparam logic [7:0] PAD_BYTE      = 8'h80;
    localparam logic [5:0] LENGTH_OFFSET = 6'd56;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] iv(input logic [2:0] i);
        case (i)
            3'd0: iv = 32'h6a09e667;
            3'd1: iv = 32'hbb67ae85;
            3'd2: iv = 32'h3c6ef372;
            3'd3: iv = 32'ha54ff53a;
            3'd4: iv = 32'h510e527f;
            3'd5: iv = 32'h9b05688c;
            3'd6: iv = 32'h1f83d9ab;
            default: iv = 32'h5be0cd19;
        endcase
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        case (t)
            6'd0:  round_k = 32'h428a2f98; 6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf; 6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b; 6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4; 6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98; 6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be; 6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74; 6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7; 6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1; 6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6; 6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f; 6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc; 6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152; 6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8; 6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3; 6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351; 6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85; 6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc; 6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354; 6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e; 6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1; 6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70; 6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819; 6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585; 6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116; 6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c; 6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3; 6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f; 6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee; 6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814; 6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa; 6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;
            default: round_k = 32'hc67178f2;
        endcase
    endfunction

endpackage

>>> rtl/sha_front.sv
module sha_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  sha_pkg::t_in_item i_item,
    input  logic              i_q_full,
    output logic              o_q_push,
    output sha_pkg::t_word    o_q_word
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_P80  = 2'd1;
    localparam logic [1:0] S_PZ   = 2'd2;
    localparam logic [1:0] S_PLEN = 2'd3;

    logic [1:0]  r_st, n_st;
    logic [23:0] r_acc;
    logic [5:0]  r_cnt;
    logic [63:0] r_len, n_len;
    logic [2:0]  r_li, n_li;
    logic        emit;
    logic [7:0]  bval;
    logic        room;
    logic        accept;

    assign full   = (r_st != S_IDLE) || i_q_full;
    assign accept = push && !full;
    assign room   = !((r_cnt[1:0] == 2'd3) && i_q_full);

    always_comb begin
        n_st  = r_st;
        n_len = r_len;
        n_li  = r_li;
        emit  = 1'b0;
        bval  = i_item.data_byte;
        case (r_st)
            S_IDLE: begin
                if (accept) begin
                    emit = i_item.has_byte;
                    if (i_item.has_byte) n_len = r_len + 64'd8;
                    if (i_item.end_of_message) n_st = S_P80;
                end
            end
            S_P80: begin
                bval = sha_pkg::PAD_BYTE;
                emit = room;
                if (room) n_st = S_PZ;
            end
            S_PZ: begin
                bval = 8'h00;
                if (r_cnt == sha_pkg::LENGTH_OFFSET) begin
                    n_st = S_PLEN;
                    n_li = 3'd0;
                end else begin
                    emit = room;
                end
            end
            default: begin
                bval = r_len[{3'd7 - r_li, 3'b000} +: 8];
                emit = room;
                if (room) begin
                    n_li = r_li + 3'd1;
                    if (r_li == 3'd7) begin
                        n_st  = S_IDLE;
                        n_len = '0;
                    end
                end
            end
        endcase
    end

    assign o_q_push      = emit && (r_cnt[1:0] == 2'd3);
    assign o_q_word.data = {r_acc, bval};
    assign o_q_word.last = (r_st == S_PLEN) && (r_li == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_cnt <= '0;
            r_len <= '0;
            r_li  <= '0;
        end else begin
            r_st  <= n_st;
            r_len <= n_len;
            r_li  <= n_li;
            if (emit) r_cnt <= r_cnt + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) r_acc <= {r_acc[15:0], bval};
    end

endmodule

>>> rtl/sha_fifo.sv
module sha_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sha_pkg::t_word i_word,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output sha_pkg::t_word o_word
);

    sha_pkg::t_word r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_word  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 2'd1;
            if (do_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b00, do_push} - {2'b00, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_word;
    end

endmodule

>>> rtl/sha_back.sv
`include "assert_macros.svh"

module sha_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  sha_pkg::t_word     i_q_word,
    output logic               o_q_pop,
    output logic               empty,
    input  logic               pop,
    output sha_pkg::t_out_item o_result
);

    localparam logic [1:0] S_RUN = 2'd0;
    localparam logic [1:0] S_FIN = 2'd1;
    localparam logic [1:0] S_OUT = 2'd2;

    logic [1:0]  r_st;
    logic [5:0]  r_t;
    logic        r_last;
    logic [2:0]  r_oidx;
    logic [31:0] r_h  [8];
    logic [31:0] r_wk [8];
    logic [31:0] r_w  [16];
    logic        step;
    logic [31:0] w_cur, w_new, s0, s1, t1, t2, big0, big1, ch, maj;

    // schedule expansion from the 16-word window, oldest at index 0
    assign s0    = sha_pkg::rotr(r_w[1], 7) ^ sha_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
    assign s1    = sha_pkg::rotr(r_w[14], 17) ^ sha_pkg::rotr(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_new = r_w[0] + s0 + r_w[9] + s1;
    assign w_cur = r_t[5:4] == 2'b00 ? i_q_word.data : w_new;

    assign step    = (r_st == S_RUN) && ((r_t[5:4] != 2'b00) || !i_q_empty);
    assign o_q_pop = step && (r_t[5:4] == 2'b00);

    assign big1 = sha_pkg::rotr(r_wk[4], 6) ^ sha_pkg::rotr(r_wk[4], 11)
                ^ sha_pkg::rotr(r_wk[4], 25);
    assign ch   = (r_wk[4] & r_wk[5]) ^ (~r_wk[4] & r_wk[6]);
    assign t1   = r_wk[7] + big1 + ch + sha_pkg::round_k(r_t) + w_cur;
    assign big0 = sha_pkg::rotr(r_wk[0], 2) ^ sha_pkg::rotr(r_wk[0], 13)
                ^ sha_pkg::rotr(r_wk[0], 22);
    assign maj  = (r_wk[0] & r_wk[1]) ^ (r_wk[0] & r_wk[2]) ^ (r_wk[1] & r_wk[2]);
    assign t2   = big0 + maj;

    assign empty                = (r_st != S_OUT);
    assign o_result.digest_word = r_h[r_oidx];
    assign o_result.word_index  = r_oidx;
    assign o_result.last_word   = (r_oidx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_RUN;
            r_t    <= '0;
            r_oidx <= '0;
            r_last <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_h[i]  <= sha_pkg::iv(3'(i));
                r_wk[i] <= sha_pkg::iv(3'(i));
            end
        end else begin
            case (r_st)
                S_RUN: begin
                    if (step) begin
                        r_wk[0] <= t1 + t2;
                        r_wk[1] <= r_wk[0];
                        r_wk[2] <= r_wk[1];
                        r_wk[3] <= r_wk[2];
                        r_wk[4] <= r_wk[3] + t1;
                        r_wk[5] <= r_wk[4];
                        r_wk[6] <= r_wk[5];
                        r_wk[7] <= r_wk[6];
                        r_t     <= r_t + 6'd1;
                        if (r_t == 6'd15) r_last <= i_q_word.last;
                        if (r_t == 6'd63) r_st <= S_FIN;
                    end
                end
                S_FIN: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i]  <= r_h[i] + r_wk[i];
                        r_wk[i] <= r_h[i] + r_wk[i];
                    end
                    r_oidx <= '0;
                    r_st   <= r_last ? S_OUT : S_RUN;
                end
                S_OUT: begin
                    if (pop) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_st <= S_RUN;
                            for (int i = 0; i < 8; i++) begin
                                r_h[i]  <= sha_pkg::iv(3'(i));
                                r_wk[i] <= sha_pkg::iv(3'(i));
                            end
                        end
                    end
                end
                default: r_st <= S_RUN;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
            r_w[15] <= w_cur;
        end
    end

    `ASSERT_IMP(a_no_pop_busy, i_clk, i_rst_n, r_st != S_RUN, !o_q_pop)
    `ASSERT_NXT(a_fin_wraps, i_clk, i_rst_n, r_st == S_FIN, r_t == 6'd0 && r_oidx == 3'd0)
    `ASSERT_NXT(a_idx_hold, i_clk, i_rst_n, r_st == S_OUT && !pop, $stable(r_oidx))
    `ASSERT_IMP(a_idx_zero, i_clk, i_rst_n, r_st == S_RUN, r_oidx == 3'd0)

endmodule

>>> rtl/sha256_message_hasher_top.sv
// sha-256 hasher, one message byte per request
// input queue side: push/full with i_item; has_byte=0 items carry no byte,
// end_of_message closes the message (an end with no byte alone = empty message)
// result queue side: empty/pop with o_result, eight digest words per message,
// word_index 0 first, last_word set on the eighth
// the front packs bytes into words at one byte a cycle while the word queue
// has room, then appends the pad and 64-bit length after the closing request
// (stalling while the word queue is full; full stays high meanwhile)
// a four-word queue feeds the round engine, which runs one round a cycle
// while it has a message word (it stalls on an empty word queue):
// 64 rounds plus a finishing step per 64-byte block; the front takes bytes of
// the next block while the rounds run, until the word queue fills
// reset (synchronous, active low) loads the initial hash and empties all queues
// when the receiver does not pop, the digest words wait and the round engine
// holds; the front keeps accepting until the word queue fills
module sha256_message_hasher_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  sha_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output sha_pkg::t_out_item o_result
);

    logic           q_push, q_full, q_pop, q_empty;
    sha_pkg::t_word q_in, q_out;

    sha_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_word (q_in)
    );

    sha_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_word  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_word  (q_out)
    );

    sha_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_word  (q_out),
        .o_q_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result)
    );

endmodule
